FILE: sv/clro_pkg.sv
package clro_pkg;

  typedef enum logic [1:0] {
    MODE_FIFO = 2'd0,
    MODE_LRU  = 2'd1,
    MODE_MRU  = 2'd2,
    MODE_ALT  = 2'd3
  } policy_mode_t;

  localparam policy_mode_t MODE_RESET = MODE_LRU;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic compact;
    logic push;
    logic en_line;
    logic en_evict;
  } cell_ctl_t;

endpackage

FILE: sv/cache_line_replacement_order.sv
// An input transfer is captured in S_IDLE; S_PURGE then runs up to two compact steps
// through the cell chain and one insert step (no insert on a FIFO access), and S_REPORT
// hands the result over in one report step once the output register is free. The next
// input is taken only in S_IDLE. A waiting result does not block the next input transfer.
// Reset (rst_n low, synchronous): the list is empty, the policy is LRU, no result pending.
module cache_line_replacement_order
  import clro_pkg::*;
#(
  parameter int ENTRIES       = 16,
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // line_address[31:0], evicted_address[63:32]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // victim_address[31:0], victim_valid[32], dropped[33], entry_count[38:34], zero[39]
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = ADDRESS_WIDTH;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PURGE,
    S_REPORT
  } state_t;

  state_t        state_r;
  policy_mode_t  mode_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] line_r;
  logic [AW-1:0] evict_r;
  logic          en_line_r;
  logic          en_evict_r;
  logic          drop_r;
  logic          out_tvalid_r;
  logic [31:0]   victim_r;
  logic          victim_valid_r;
  logic          dropped_r;
  logic [4:0]    entry_count_r;

  cell_ctl_t     ctl;
  logic          any_hole;
  logic [AW-1:0] head_q;
  logic [AW-1:0] tail_q;
  logic          cfg_wr;
  logic          list_full;
  logic          out_free;
  logic [AW-1:0] victim_sel;

  assign in_tready  = state_r == S_IDLE;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {30'd0, mode_r};
  assign list_full  = count_r == CW'(ENTRIES);
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    ctl.en_line  = en_line_r;
    ctl.en_evict = en_evict_r;
    ctl.compact  = (state_r == S_PURGE) && any_hole;
    ctl.push     = (state_r == S_PURGE) && !any_hole && en_line_r;
  end

  always_comb begin
    if (count_r == '0) begin
      victim_sel = '0;
    end else if (mode_r == MODE_MRU) begin
      victim_sel = head_q;
    end else begin
      victim_sel = tail_q;
    end
  end

  clro_chain #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .CW      (CW)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .count     (count_r),
    .key_line  (line_r),
    .key_evict (evict_r),
    .any_hole  (any_hole),
    .head_q    (head_q),
    .tail_q    (tail_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_RESET;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
      en_line_r    <= 1'b0;
      en_evict_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_r <= policy_mode_t'(cfg_pwdata[1:0]);
      end
      if (state_r == S_REPORT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            line_r     <= AW'(in_tdata[31:0]);
            evict_r    <= AW'(in_tdata[63:32]);
            en_line_r  <= in_tuser || (mode_r != MODE_FIFO);
            en_evict_r <= in_tuser;
            drop_r     <= 1'b0;
            state_r    <= S_PURGE;
          end
        end
        S_PURGE: begin
          if (any_hole) begin
            count_r <= count_r - CW'(1);
          end else begin
            if (en_line_r) begin
              if (list_full) begin
                drop_r <= 1'b1;
              end else begin
                count_r <= count_r + CW'(1);
              end
            end
            state_r <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            victim_r       <= 32'(victim_sel);
            victim_valid_r <= count_r != '0;
            dropped_r      <= drop_r;
            entry_count_r  <= 5'(count_r);
            en_line_r      <= 1'b0;
            en_evict_r     <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, entry_count_r, dropped_r, victim_valid_r, victim_r};

endmodule

FILE: sv/clro_cell.sv
module clro_cell
  import clro_pkg::*;
#(
  parameter int AW = 32
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic          entry_valid,
  input  logic [AW-1:0] key_line,
  input  logic [AW-1:0] key_evict,
  input  logic [AW-1:0] head_side_q,
  input  logic [AW-1:0] tail_side_q,
  input  logic          hole_in,
  output logic          hole_out,
  output logic [AW-1:0] entry_q
);

  logic [AW-1:0] entry_r;
  logic [AW-1:0] entry_nxt;
  logic          match;

  always_comb begin
    match = entry_valid &&
            ((ctl.en_line && (entry_r == key_line)) ||
             (ctl.en_evict && (entry_r == key_evict)));
    hole_out = hole_in | match;
  end

  // A compact step closes the first hole: every cell at or behind it pulls
  // from its tail-side neighbor. A push moves everything one cell toward the tail.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.compact && hole_out) begin
      entry_nxt = tail_side_q;
    end else if (ctl.push) begin
      entry_nxt = head_side_q;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

FILE: sv/clro_chain.sv
module clro_chain
  import clro_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int AW      = 32,
  parameter int CW      = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] count,
  input  logic [AW-1:0] key_line,
  input  logic [AW-1:0] key_evict,
  output logic          any_hole,
  output logic [AW-1:0] head_q,
  output logic [AW-1:0] tail_q
);

  logic [AW-1:0]    q     [ENTRIES];
  logic [ENTRIES:0] hole;
  logic [ENTRIES-1:0] tail_sel;

  assign hole[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [AW-1:0] head_side;
    logic [AW-1:0] tail_side;
    logic          valid;

    if (i == 0) begin : g_head
      assign head_side = key_line;
    end else begin : g_mid
      assign head_side = q[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign tail_side = q[i];
    end else begin : g_inner
      assign tail_side = q[i+1];
    end

    assign valid       = CW'(i) < count;
    assign tail_sel[i] = count == CW'(i + 1);

    clro_cell #(
      .AW(AW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .entry_valid (valid),
      .key_line    (key_line),
      .key_evict   (key_evict),
      .head_side_q (head_side),
      .tail_side_q (tail_side),
      .hole_in     (hole[i]),
      .hole_out    (hole[i+1]),
      .entry_q     (q[i])
    );
  end

  assign any_hole = hole[ENTRIES];
  assign head_q   = q[0];

  always_comb begin
    tail_q = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tail_q = tail_q | (tail_sel[i] ? q[i] : '0);
    end
  end

endmodule

FILE: sv/clro_checker.sv
module clro_checker #(
  parameter int ENTRIES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32] == (out_tdata[38:34] != 5'd0)) || (ENTRIES > 31))
    else $error("Victim valid flag disagrees with the entry count.");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[38:34] == 5'(ENTRIES))
    else $error("Dropped flag raised on a list that is not full.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken while an item is still in work.");

endmodule

bind cache_line_replacement_order clro_checker #(.ENTRIES(ENTRIES)) u_clro_checker (.*);

FILE: tb/cache_line_replacement_order_tb.sv
module cache_line_replacement_order_tb;
  import clro_pkg::*;

  localparam int          ENTRIES         = 16;
  localparam int          RANDOM_PHASES   = 9;
  localparam int          PHASE_ITEMS     = 100;
  localparam int          POOL_SIZE       = 24;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          LONG_STALL      = 300;
  localparam logic        KIND_ACCESS     = 1'b0;
  localparam logic        KIND_REPLACE    = 1'b1;
  localparam logic [2:0]  POLICY_REG_ADDR = 3'd0;

  typedef struct packed {
    logic        kind;
    logic [31:0] line;
    logic [31:0] evict;
  } line_op_t;

  typedef struct packed {
    logic [31:0] victim;
    logic        valid;
    logic        dropped;
    logic [4:0]  count;
  } order_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // line_address[31:0], evicted_address[63:32]
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  // victim_address[31:0], victim_valid[32], dropped[33], entry_count[38:34], zero[39]
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  line_op_t      pending_ops[$];
  order_report_t expected_reports[$];
  logic [31:0]   resident_order[ENTRIES];
  int            resident_count;
  policy_mode_t  cur_mode;
  logic [31:0]   addr_pool[POOL_SIZE];

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_trigger;
  bit long_stall;
  int mismatches;
  int ops_sent;
  int reports_seen;
  int drops_seen;
  int empty_seen;

  policy_mode_t phase_modes[RANDOM_PHASES] = '{MODE_FIFO, MODE_LRU, MODE_MRU, MODE_ALT, MODE_MRU,
                                               MODE_FIFO, MODE_LRU, MODE_MRU, MODE_FIFO};

  cache_line_replacement_order i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void remove_address(logic [31:0] addr);
    int wr;
    wr = 0;
    for (int rd = 0; rd < resident_count; rd++) begin
      if (resident_order[rd] != addr) begin
        resident_order[wr] = resident_order[rd];
        wr++;
      end
    end
    resident_count = wr;
  endfunction

  function automatic bit insert_head(logic [31:0] addr);
    bit lost;
    lost = 1'b0;
    if (resident_count >= ENTRIES) begin
      resident_count = ENTRIES - 1;
      lost = 1'b1;
    end
    for (int i = resident_count; i > 0; i--) resident_order[i] = resident_order[i - 1];
    resident_order[0] = addr;
    resident_count++;
    return lost;
  endfunction

  function automatic void track_order(line_op_t op);
    order_report_t rep;
    bit lost;
    lost = 1'b0;
    if (op.kind == KIND_REPLACE) begin
      remove_address(op.evict);
      remove_address(op.line);
      lost = insert_head(op.line);
    end else if (cur_mode != MODE_FIFO) begin
      remove_address(op.line);
      lost = insert_head(op.line);
    end
    rep.valid   = resident_count > 0;
    rep.victim  = 32'd0;
    if (rep.valid)
      rep.victim = (cur_mode == MODE_MRU) ? resident_order[0] : resident_order[resident_count - 1];
    rep.dropped = lost;
    rep.count   = resident_count[4:0];
    expected_reports.push_back(rep);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %h, expected %h", reports_seen, what, got, want);
    mismatches++;
  endtask

  task automatic write_policy(policy_mode_t mode);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= POLICY_REG_ADDR;
    cfg_pwdata  <= {30'd0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_mode = mode;
  endtask

  task automatic drain_all();
    while (pending_ops.size() != 0 || in_tvalid || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: when the bus is free or the item was taken, the next one may be offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= KIND_ACCESS;
    end else begin
      if (in_tvalid && in_tready) begin
        track_order('{in_tuser, in_tdata[31:0], in_tdata[63:32]});
        ops_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          line_op_t op;
          op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {op.evict, op.line};
          in_tuser  <= op.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
        end else begin
          order_report_t want;
          want = expected_reports.pop_front();
          if (out_tdata[31:0] !== want.victim)
            report_mismatch("victim_address", out_tdata[31:0], want.victim);
          if (out_tdata[32] !== want.valid)
            report_mismatch("victim_valid", {31'd0, out_tdata[32]}, {31'd0, want.valid});
          if (out_tdata[33] !== want.dropped)
            report_mismatch("dropped", {31'd0, out_tdata[33]}, {31'd0, want.dropped});
          if (out_tdata[38:34] !== want.count)
            report_mismatch("entry_count", {27'd0, out_tdata[38:34]}, {27'd0, want.count});
          if (want.dropped) drops_seen++;
          if (!want.valid) empty_seen++;
        end
        reports_seen++;
      end
      out_tready <= !long_stall && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering.
  initial begin
    long_stall = 1'b0;
    wait (stall_trigger);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    long_stall <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d results outstanding.", expected_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    line_op_t op;
    rst_n         = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    stall_trigger = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 78;
    mismatches    = 0;
    ops_sent      = 0;
    reports_seen  = 0;
    drops_seen    = 0;
    empty_seen    = 0;
    resident_count = 0;
    cur_mode      = MODE_RESET;
    foreach (resident_order[i]) resident_order[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part in FIFO mode: empty list, fill past capacity, hits and duplicates.
    write_policy(MODE_FIFO);
    pending_ops.push_back('{KIND_ACCESS, 32'h1234_5678, 32'h0});
    pending_ops.push_back('{KIND_REPLACE, 32'h0000_0000, 32'hFFFF_FFFF});
    pending_ops.push_back('{KIND_REPLACE, 32'hFFFF_FFFF, 32'h0000_0001});
    pending_ops.push_back('{KIND_REPLACE, 32'hAAAA_AAAA, 32'h8000_0000});
    pending_ops.push_back('{KIND_REPLACE, 32'h5555_5555, 32'h7FFF_FFFF});
    for (int i = 1; i <= 13; i++)
      pending_ops.push_back('{KIND_REPLACE, 32'h0101_0101 * i, 32'hDEAD_BEEF});
    pending_ops.push_back('{KIND_REPLACE, 32'h0303_0303, 32'h5555_5555});
    pending_ops.push_back('{KIND_ACCESS, 32'hFFFF_FFFF, 32'h0});
    pending_ops.push_back('{KIND_REPLACE, 32'h0707_0707, 32'h0707_0707});
    drain_all();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 78;
      end else if (p < 6) begin
        send_idle_pct = 78;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_policy(phase_modes[p]);
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      if (p == 6) stall_trigger = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == PHASE_ITEMS / 2) drain_all();
        op.kind  = 1'($urandom_range(1));
        op.line  = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        op.evict = ($urandom_range(99) < 60) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        pending_ops.push_back(op);
      end
      drain_all();
    end

    if (expected_reports.size() != 0)
      report_mismatch("results never delivered", expected_reports.size(), 32'd0);
    $display("Sent %0d items through FIFO, LRU, MRU and the spare mode code; %0d results checked.",
             ops_sent, reports_seen);
    $display("Seen %0d dropped tails and %0d empty-list reports; %0d mismatches.",
             drops_seen, empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
